[src/plt_pkg.sv]
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants for the point list table: opcodes, status codes,
// controller states, point and transfer payloads, cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

    localparam int COORD_BITS       = 8;
    localparam int DEFAULT_CAPACITY = 32;
    localparam int MIN_FOR_REMOVE   = 3;
    localparam int DEFAULT_COUNT    = 2;

    localparam logic [COORD_BITS-1:0] DEFAULT_LOW  = '0;
    localparam logic [COORD_BITS-1:0] DEFAULT_HIGH = 8'd255;

    typedef enum logic [2:0] {
        OP_SEARCH = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_RESET  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FEW   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } point_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [5:0]            position;
        logic [COORD_BITS-1:0] key_x;
        logic [COORD_BITS-1:0] value_y;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [5:0]            where;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [5:0]            entries;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic load_dflt;
    } cell_ctl_t;

endpackage

`default_nettype wire

[src/point_list_table_core.sv]
// ----------------------------------------------------------------------------
// point_list_table_core
// Ordered list of up to CAPACITY points held in a ring of cells; search,
// insert, remove, get and list reset, one request and one result at a time.
// ----------------------------------------------------------------------------
//
//  channel  | ports                        | payload
//  ---------+------------------------------+---------------------------------
//  request  | s_valid, s_ready, s_data     | opcode, position, key_x, value_y
//  result   | m_valid, m_ready, m_data     | status, found, where, point_x,
//           |                              | point_y, entries
//
//  Search, insert, remove and get with a legal index rotate the cell ring
//  once around in the scan state after the request transfer; the result
//  is then offered from the done state, and the next request can be taken
//  in the cycle after the result transfer, from the idle state.
//  Rejected requests, list reset and unused opcodes skip the scan and allow
//  the result transfer in the cycle after the request transfer.
//  Reset leaves the list (0,0),(255,255) with two entries; no clearing pass.
//  A stalled result holds in the output registers; s_ready stays low until
//  the result transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module point_list_table_core #(
    parameter int CAPACITY = plt_pkg::DEFAULT_CAPACITY
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire plt_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output plt_pkg::out_item_t     m_data
);
    import plt_pkg::*;

    // ring of cells: cell i takes cell i+1 on each rotate step, the last cell
    // takes the rewritten stream from the sequencer
    point_t    cell_q [CAPACITY];
    point_t    feed;
    cell_ctl_t cell_ctl;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            point_t shift_in;
            point_t dflt_val;

            if (gi == CAPACITY - 1) begin : g_tail
                assign shift_in = feed;
            end else begin : g_body
                assign shift_in = cell_q[gi + 1];
            end

            // only the first two entries carry defined reset contents
            assign dflt_val = (gi == 0) ? point_t'{x: DEFAULT_LOW,  y: DEFAULT_LOW}
                                        : point_t'{x: DEFAULT_HIGH, y: DEFAULT_HIGH};

            plt_cell u_cell (
                .aclk     (aclk),
                .cell_ctl (cell_ctl),
                .shift_in (shift_in),
                .dflt_en  (gi < DEFAULT_COUNT),
                .dflt_val (dflt_val),
                .data_q   (cell_q[gi])
            );
        end
    endgenerate

    // sequencer watches the two head cells and drives the tail
    plt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .head0    (cell_q[0]),
        .head1    (cell_q[1]),
        .feed     (feed),
        .cell_ctl (cell_ctl)
    );

endmodule

`default_nettype wire

[src/plt_cell.sv]
// ----------------------------------------------------------------------------
// plt_cell
// One list entry. Takes its neighbor's point while the chain rotates, or its
// default point, if it has one, when the list is reset.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_cell (
    input  wire logic               aclk,
    input  wire plt_pkg::cell_ctl_t cell_ctl,
    input  wire plt_pkg::point_t    shift_in,
    input  wire logic               dflt_en,
    input  wire plt_pkg::point_t    dflt_val,
    output plt_pkg::point_t         data_q
);
    import plt_pkg::*;

    point_t data_reg;

    always_ff @(posedge aclk) begin
        if (cell_ctl.shift) begin
            data_reg <= shift_in;
        end else if (cell_ctl.load_dflt && dflt_en) begin
            data_reg <= dflt_val;
        end
    end

    assign data_q = data_reg;

endmodule

`default_nettype wire

[src/plt_ctrl.sv]
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer for the point list: checks each request, rotates the cell chain
// once around for a request that passes the check while watching the head,
// and builds the rewritten stream that re-enters at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ctrl #(
    parameter int CAPACITY = plt_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire plt_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output plt_pkg::out_item_t       m_data,
    input  wire plt_pkg::point_t     head0,
    input  wire plt_pkg::point_t     head1,
    output plt_pkg::point_t          feed,
    output plt_pkg::cell_ctl_t       cell_ctl
);
    import plt_pkg::*;

    localparam int KW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    state_t                state_reg, state_next;
    in_item_t              req_reg;
    logic [KW-1:0]         k_reg;
    logic [CW-1:0]         count_reg;
    point_t                hold_reg, hold_next;
    status_t               status_reg;
    logic                  found_reg;
    logic [CW-1:0]         where_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  srch_done_reg;

    logic                  accept;
    logic                  last;
    logic [PW-1:0]         pos_w, rpos_w, k_w, cnt_w;
    status_t               status_dec;
    logic                  scan_dec;
    logic [CW-1:0]         cnt_dec;
    logic                  stop;
    logic                  capture;

    assign accept = s_valid && s_ready;
    assign last   = (k_reg == KW'(CAPACITY - 1));
    assign pos_w  = PW'(s_data.position);
    assign rpos_w = PW'(req_reg.position);
    assign k_w    = PW'(k_reg);
    assign cnt_w  = PW'(count_reg);

    // request check against the current count
    always_comb begin
        status_dec = STAT_OK;
        scan_dec   = 1'b0;
        cnt_dec    = count_reg;
        unique case (s_data.opcode)
            OP_SEARCH: begin
                scan_dec = 1'b1;
            end
            OP_INSERT: begin
                if (count_reg >= CW'(CAPACITY)) begin
                    status_dec = STAT_FULL;
                end else if (pos_w > cnt_w) begin
                    status_dec = STAT_RANGE;
                end else begin
                    scan_dec = 1'b1;
                    cnt_dec  = count_reg + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (count_reg < CW'(MIN_FOR_REMOVE)) begin
                    status_dec = STAT_FEW;
                end else if (pos_w >= cnt_w) begin
                    status_dec = STAT_RANGE;
                end else begin
                    scan_dec = 1'b1;
                    cnt_dec  = count_reg - 1'b1;
                end
            end
            OP_GET: begin
                if (pos_w >= cnt_w) begin
                    status_dec = STAT_RANGE;
                end else begin
                    scan_dec = 1'b1;
                end
            end
            OP_RESET: begin
                cnt_dec = CW'(DEFAULT_COUNT);
            end
            default: begin
            end
        endcase
    end

    // tail stream: entry k leaves the head at step k
    always_comb begin
        feed      = head0;
        hold_next = hold_reg;
        unique case (req_reg.opcode)
            OP_INSERT: begin
                if (k_w == rpos_w) begin
                    feed      = '{x: req_reg.key_x, y: req_reg.value_y};
                    hold_next = head0;
                end else if (k_w > rpos_w) begin
                    feed      = hold_reg;
                    hold_next = head0;
                end
            end
            OP_REMOVE: begin
                if (k_w >= rpos_w) begin
                    feed = last ? '0 : head1;
                end
            end
            default: begin
            end
        endcase
    end

    assign stop = (req_reg.opcode == OP_SEARCH) && !srch_done_reg && (k_w < cnt_w)
                  && !(head0.x < req_reg.key_x);
    assign capture = (req_reg.opcode == OP_GET) && (k_w == rpos_w);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = scan_dec ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // reset, or an accepted list reset request, loads the two default entries into the head cells
    always_comb begin
        s_ready            = aresetn && (state_reg == S_IDLE);
        m_valid            = aresetn && (state_reg == S_DONE);
        cell_ctl.shift     = aresetn && (state_reg == S_SCAN);
        cell_ctl.load_dflt = !aresetn
                             || (accept && (s_data.opcode == OP_RESET));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(DEFAULT_COUNT);
            k_reg         <= '0;
            srch_done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg     <= cnt_dec;
                k_reg         <= '0;
                srch_done_reg <= 1'b0;
            end else if (state_reg == S_SCAN) begin
                k_reg <= last ? '0 : k_reg + 1'b1;
                if (stop) begin
                    srch_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_data;
            status_reg <= status_dec;
            found_reg  <= 1'b0;
            where_reg  <= (s_data.opcode == OP_SEARCH) ? count_reg : '0;
            px_reg     <= '0;
            py_reg     <= '0;
        end else if (state_reg == S_SCAN) begin
            hold_reg <= hold_next;
            if (stop) begin
                where_reg <= CW'(k_reg);
                found_reg <= (head0.x == req_reg.key_x);
            end
            if (capture) begin
                px_reg <= head0.x;
                py_reg <= head0.y;
            end
        end
    end

    assign m_data = '{status:  status_reg,
                      found:   found_reg,
                      where:   6'(where_reg),
                      point_x: px_reg,
                      point_y: py_reg,
                      entries: 6'(count_reg)};

    a_count_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY) && count_reg >= CW'(DEFAULT_COUNT))
        else $error("entry count left its legal range");

    a_scan_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) && !last |=> (state_reg == S_SCAN) && (k_reg == $past(k_reg) + 1'b1))
        else $error("scan step counter skipped");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.opcode == OP_INSERT) && (status_dec == STAT_OK)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the list");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STAT_OK) |-> !m_data.found && (m_data.point_x == '0))
        else $error("failed operation reports stale fields");

endmodule

`default_nettype wire

[test/point_list_table_core_test.sv]
// ----------------------------------------------------------------------------
// point_list_table_core_test
// Self-checking bench for the point list table. A sequential shadow of the
// list predicts every result at the request transfer; a checker compares each
// result transfer field by field. Directed edge cases come first, then random
// edit traffic, a fill under long result back-pressure and more random traffic
// that sweep the list between its minimum and full, under three idling profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module point_list_table_core_test;

    import plt_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int LONG_HOLD   = 400;       // cycles the receiver refuses results
    localparam int DRAIN_LIMIT = 20000;     // cycles allowed to collect stragglers
    localparam int TIMEOUT     = 2000000;   // time units for the whole run
    localparam int MAX_REPORTS = 10;

    // Opcodes the block has no use for; they must pass through untouched.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [5:0] POS_MAX = 6'd63;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    // Shadow of the list, advanced in request order by the sender.
    logic [COORD_BITS-1:0] list_x [CAPACITY];
    logic [COORD_BITS-1:0] list_y [CAPACITY];
    int                    list_count;
    bit                    growing = 1'b1;

    out_item_t pending_results [$];
    int        error_count = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Receiver hold-off control: armed once by the pressure test.
    logic hold_armed  = 1'b0;
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;

    always #2 aclk = ~aclk;

    point_list_table_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // List prediction
    // ------------------------------------------------------------------------

    // Restore the two-entry default list.
    function automatic void load_default_list();
        for (int i = 0; i < CAPACITY; i++) begin
            list_x[i] = '0;
            list_y[i] = '0;
        end
        list_x[0]  = DEFAULT_LOW;
        list_y[0]  = DEFAULT_LOW;
        list_x[1]  = DEFAULT_HIGH;
        list_y[1]  = DEFAULT_HIGH;
        list_count = DEFAULT_COUNT;
    endfunction

    // Apply one request to the shadow list and return the result it yields.
    function automatic out_item_t apply_list_request(input in_item_t req);
        out_item_t res;
        int        pos;
        int        i;
        res = '0;
        res.status = STAT_OK;
        pos = int'(req.position);
        case (req.opcode)
            OP_SEARCH: begin
                i = 0;
                while (i < list_count && list_x[i] < req.key_x)
                    i++;
                res.found = (i < list_count) && (list_x[i] == req.key_x);
                res.where = 6'(i);
            end
            OP_INSERT: begin
                // Full takes priority over a bad index.
                if (list_count >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else if (pos > list_count) begin
                    res.status = STAT_RANGE;
                end else begin
                    for (i = list_count; i > pos; i--) begin
                        list_x[i] = list_x[i-1];
                        list_y[i] = list_y[i-1];
                    end
                    list_x[pos] = req.key_x;
                    list_y[pos] = req.value_y;
                    list_count++;
                end
            end
            OP_REMOVE: begin
                // Too few entries takes priority over a bad index.
                if (list_count < MIN_FOR_REMOVE) begin
                    res.status = STAT_FEW;
                end else if (pos >= list_count) begin
                    res.status = STAT_RANGE;
                end else begin
                    for (i = pos; i + 1 < list_count; i++) begin
                        list_x[i] = list_x[i+1];
                        list_y[i] = list_y[i+1];
                    end
                    list_count--;
                    list_x[list_count] = '0;
                    list_y[list_count] = '0;
                end
            end
            OP_GET: begin
                if (pos >= list_count) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.point_x = list_x[pos];
                    res.point_y = list_y[pos];
                end
            end
            OP_RESET: load_default_list();
            default: ;  // spare opcodes change nothing
        endcase
        res.entries = 6'(list_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request, hold it until the transfer, then predict its result.
    // Valid stays high after the transfer so back-to-back requests never
    // drop it within one step; a gap lowers it first.
    task automatic send_request(input in_item_t req);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct / 8) begin
            // Occasional long gap to land on a different phase of the scan.
            gap = $urandom_range(1, 40);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(apply_list_request(req));
        // Sweep direction: fill up to capacity, then drain to the minimum.
        if (list_count >= CAPACITY)
            growing = 1'b0;
        else if (list_count <= DEFAULT_COUNT)
            growing = 1'b1;
    endtask

    task automatic send_op(input opcode_t op, input logic [5:0] pos,
                           input logic [COORD_BITS-1:0] kx,
                           input logic [COORD_BITS-1:0] vy);
        in_item_t req;
        req.opcode   = op;
        req.position = pos;
        req.key_x    = kx;
        req.value_y  = vy;
        send_request(req);
    endtask

    // Index mostly inside [0, span), sometimes anywhere in the field.
    function automatic logic [5:0] pick_position(input int span);
        int r;
        r = $urandom_range(0, 99);
        if (span <= 0 || r < 15)
            return 6'($urandom_range(0, 63));
        if (r < 25)
            return 6'(span - 1);
        if (r < 32)
            return 6'd0;
        return 6'($urandom_range(0, span - 1));
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Random back-pressure, plus one long hold-off counted here when armed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected result transfer: status %0d entries %0d",
                             m_data.status, m_data.entries);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status  !== want.status  || m_data.found   !== want.found   ||
                    m_data.where   !== want.where   || m_data.point_x !== want.point_x ||
                    m_data.point_y !== want.point_y || m_data.entries !== want.entries) begin
                    if (error_count < MAX_REPORTS) begin
                        $write("result mismatch: want st %0d fnd %0d whr %0d x %0h y %0h n %0d",
                               want.status, want.found, want.where, want.point_x,
                               want.point_y, want.entries);
                        $display(", got st %0d fnd %0d whr %0d x %0h y %0h n %0d",
                                 m_data.status, m_data.found, m_data.where,
                                 m_data.point_x, m_data.point_y, m_data.entries);
                    end
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Read and search the list exactly as reset leaves it.
    task automatic test_default_list();
        send_op(OP_GET,    6'd0, '0, '0);
        send_op(OP_GET,    6'd1, '0, '0);
        send_op(OP_GET,    6'd2, '0, '0);          // one past the end
        send_op(OP_SEARCH, 6'd0, 8'h00, '0);       // hit at the front
        send_op(OP_SEARCH, 6'd0, 8'hff, '0);       // hit at the back
        send_op(OP_SEARCH, 6'd0, 8'h80, '0);       // miss, lands before 255
    endtask

    // Remove is refused at the minimum, even with a bad index.
    task automatic test_remove_guard();
        send_op(OP_REMOVE, 6'd0,    '0, '0);
        send_op(OP_REMOVE, POS_MAX, '0, '0);
    endtask

    task automatic test_insert_edges();
        send_op(OP_INSERT, POS_MAX, 8'h11, 8'h22);  // far out of range
        send_op(OP_INSERT, 6'd3,    8'h11, 8'h22);  // one past count
        send_op(OP_INSERT, 6'd2,    8'hff, 8'haa);  // append at count
        send_op(OP_INSERT, 6'd0,    8'h00, 8'h55);  // at the front
        send_op(OP_INSERT, 6'd2,    8'h80, 8'hff);  // in the middle
    endtask

    task automatic test_remove_edges();
        send_op(OP_REMOVE, 6'd5, '0, '0);            // index equal to count
        send_op(OP_REMOVE, 6'd4, '0, '0);            // last entry
        send_op(OP_REMOVE, 6'd0, '0, '0);            // first entry
    endtask

    task automatic test_get_edges();
        send_op(OP_GET, POS_MAX, '0, '0);
        send_op(OP_GET, 6'(list_count - 1), '0, '0);
    endtask

    task automatic test_spare_opcodes();
        for (logic [3:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_op(opcode_t'(op[2:0]), POS_MAX, 8'hff, 8'hff);
    endtask

    task automatic test_list_reset();
        send_op(OP_RESET, POS_MAX, 8'hff, 8'hff);
        send_op(OP_GET,   6'd1, '0, '0);
    endtask

    // Fill the list to capacity while the receiver holds off, so the block
    // backs up and stalls the request side; then probe the full list.
    task automatic test_full_list_backpressure();
        hold_armed <= 1'b1;
        while (list_count < CAPACITY)
            send_op(OP_INSERT, 6'(list_count - 1), 8'(list_count * 7),
                    8'($urandom_range(0, 255)));
        send_op(OP_INSERT, POS_MAX, 8'h5a, 8'ha5);   // full wins over range
        send_op(OP_INSERT, 6'd0,    8'h5a, 8'ha5);
        send_op(OP_GET,    6'(CAPACITY - 1), '0, '0);
        send_op(OP_SEARCH, 6'd0, 8'hff, '0);
        send_op(OP_REMOVE, 6'(CAPACITY - 1), '0, '0);
        send_op(OP_REMOVE, 6'd0, '0, '0);
    endtask

    // Random edits that sweep the list between its minimum and full. Most
    // inserts keep x ascending so searches stay meaningful.
    task automatic test_random_traffic(input int n_items);
        in_item_t              req;
        int                    r;
        int                    ins_w;
        int                    rem_w;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
        for (int k = 0; k < n_items; k++) begin
            ins_w        = growing ? 55 : 15;
            rem_w        = growing ? 15 : 55;
            req.position = '0;
            req.key_x    = 8'($urandom_range(0, 255));
            req.value_y  = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                req.opcode   = OP_INSERT;
                req.position = pick_position(list_count + 1);
                if (req.position <= list_count && $urandom_range(0, 99) < 75) begin
                    lo = (req.position > 0) ? list_x[req.position - 1] : 8'h00;
                    hi = (req.position < list_count) ? list_x[req.position] : 8'hff;
                    req.key_x = 8'($urandom_range(int'(lo), int'(hi)));
                end
            end else if (r < ins_w + rem_w) begin
                req.opcode   = OP_REMOVE;
                req.position = pick_position(list_count);
            end else if (r < ins_w + rem_w + 13) begin
                req.opcode = OP_SEARCH;
                req.position = 6'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 55)
                    req.key_x = list_x[$urandom_range(0, list_count - 1)];
                else if (r < 70)
                    req.key_x = list_x[$urandom_range(0, list_count - 1)] + 8'd1;
            end else if (r < ins_w + rem_w + 25) begin
                req.opcode   = OP_GET;
                req.position = pick_position(list_count);
            end else if (r < ins_w + rem_w + 26) begin
                req.opcode   = OP_RESET;
                req.position = 6'($urandom_range(0, 63));
            end else begin
                req.opcode   = opcode_t'(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
                req.position = 6'($urandom_range(0, 63));
            end
            send_request(req);
        end
    endtask

    // Drop valid, collect every outstanding result, then give a verdict.
    task automatic finish_run();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        // Let any stray result surface before judging.
        repeat (CAPACITY + 4) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d predicted results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        load_default_list();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender mostly busy, receiver mostly stalling.
        set_idling(20, 64);
        test_default_list();
        test_remove_guard();
        test_insert_edges();
        test_remove_edges();
        test_get_edges();
        test_spare_opcodes();
        test_list_reset();
        test_random_traffic(430);

        // Sender mostly idle, receiver mostly ready.
        set_idling(64, 20);
        test_full_list_backpressure();
        test_random_traffic(420);

        // Full rate on both sides.
        set_idling(0, 0);
        test_random_traffic(430);

        finish_run();
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[point_list_table_core.f]
src/plt_pkg.sv
src/plt_cell.sv
src/plt_ctrl.sv
src/point_list_table_core.sv
test/point_list_table_core_test.sv
